>>> rtl/core/asm_statement_lexer_top_defines.svh
// Assertion macros shared by the statement lexer's checker.
`ifndef ASM_STATEMENT_LEXER_TOP_DEFINES_SVH
`define ASM_STATEMENT_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/asl_pkg.sv
// Package with the lexer's constants, phase type and character class functions.
`default_nettype none

package asl_pkg;

	localparam int NAME_BUF = 32;
	localparam int LINE_LEN = 256;
	localparam int NAME_LIM = ((NAME_BUF - 1) < 31) ? (NAME_BUF - 1) : 31;
	localparam int CMP_LIM  = NAME_BUF - 1;
	localparam int POS_MAX  = ((LINE_LEN - 1) < 255) ? (LINE_LEN - 1) : 255;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQ     = 8'h3D;

	// Keywords packed with the first character in the low byte.
	localparam logic [23:0] KW_EQU  = 24'h555145;
	localparam logic [23:0] KW_SET  = 24'h544553;
	localparam logic [31:0] KW_DEFL = 32'h4C464544;

	localparam logic [1:0] OPK_NONE  = 2'd0;
	localparam logic [1:0] OPK_IDENT = 2'd1;
	localparam logic [1:0] OPK_EQUAL = 2'd2;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_TOK1,
		PH_AFTER1,
		PH_COLON,
		PH_LBLWS,
		PH_OP,
		PH_OPWS,
		PH_EQ1,
		PH_EQ2,
		PH_TOK2,
		PH_DONE
	} phase_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_idstart(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) ||
			(c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_PCT);
	endfunction

	function automatic logic is_idchar(input logic [7:0] c);
		return is_idstart(c) || (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic [4:0] sat_name(input logic [4:0] n);
		return (32'(n) < NAME_LIM) ? (n + 5'd1) : n;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/asl_if.sv
// Handshake interfaces for the character input and the statement result.
`default_nettype none

interface asl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface asl_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] label_start;
	logic [4:0] label_len;
	logic [1:0] op_kind;
	logic [7:0] op_start;
	logic [4:0] op_len;
	logic [7:0] operands_start;
	logic       is_assign;
	logic       is_internal;
	logic       too_long;

	modport source(output valid, output label_start, output label_len, output op_kind,
		output op_start, output op_len, output operands_start, output is_assign,
		output is_internal, output too_long, input ready);
	modport sink(input valid, input label_start, input label_len, input op_kind,
		input op_start, input op_len, input operands_start, input is_assign,
		input is_internal, input too_long, output ready);
endinterface

`default_nettype wire

>>> rtl/core/asm_statement_lexer_top.sv
// Assembler statement lexer: splits one source line into label, operator and operands.
// The block takes one character per cycle except while input is held back; a zero
// byte ends the line and produces one result transfer after the terminator is taken,
// through the character register and then the result register. The character
// register also serves as a skid stage, so input is only held back while a finished
// result waits and another terminator is queued behind it. Offsets count from the
// first character of the line and stop at the line limit, which sets too_long.
`default_nettype none

module asm_statement_lexer_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	asl_char_if.sink           chars,
	asl_result_if.source       results
);

	localparam logic [7:0] POS_MAX_B = 8'(asl_pkg::POS_MAX);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       stall;
	logic       proc;
	logic       line_end;

	asl_pkg::phase_t phase_q, phase_d, ph;

	logic [7:0]  off_q, off_d;
	logic        ovf_q, ovf_d;
	logic [7:0]  first_start_q, first_start_d;
	logic [4:0]  first_len_q, first_len_d;
	logic        first_dot_q, first_dot_d;
	logic [7:0]  second_start_q, second_start_d;
	logic [31:0] second_chars_q, second_chars_d;
	logic [2:0]  second_len_q, second_len_d;
	logic [7:0]  label_start_q, label_start_d;
	logic [4:0]  label_len_q, label_len_d;
	logic [1:0]  op_kind_q, op_kind_d;
	logic [7:0]  op_start_q, op_start_d;
	logic [4:0]  op_len_q, op_len_d;
	logic [7:0]  ops_start_q, ops_start_d;
	logic        assign_q, assign_d;
	logic        internal_q, internal_d;

	logic [2:0] kw_eff;
	logic       kw_hit;
	logic [4:0] kw_len;

	logic        out_valid_q;
	logic [7:0]  out_label_start_q;
	logic [4:0]  out_label_len_q;
	logic [1:0]  out_op_kind_q;
	logic [7:0]  out_op_start_q;
	logic [4:0]  out_op_len_q;
	logic [7:0]  out_ops_start_q;
	logic        out_assign_q;
	logic        out_internal_q;
	logic        out_too_long_q;

	assign line_end = (ch_s1 == asl_pkg::CH_NUL);
	assign stall    = valid_s1 && line_end && out_valid_q && !results.ready;
	assign proc     = valid_s1 && !stall;
	assign chars.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready) begin
			ch_s1 <= chars.ch;
		end
	end

	assign kw_eff = (32'(second_len_q) > asl_pkg::CMP_LIM) ? 3'(asl_pkg::CMP_LIM)
		: second_len_q;
	assign kw_hit = ((kw_eff == 3'd3) && ((second_chars_q[23:0] == asl_pkg::KW_EQU) ||
		(second_chars_q[23:0] == asl_pkg::KW_SET))) ||
		((kw_eff == 3'd4) && (second_chars_q == asl_pkg::KW_DEFL));
	assign kw_len = (32'(kw_eff) > asl_pkg::NAME_LIM) ? 5'(asl_pkg::NAME_LIM)
		: {2'b00, kw_eff};

	always_comb begin
		phase_d        = phase_q;
		ph             = phase_q;
		off_d          = (off_q < POS_MAX_B) ? (off_q + 8'd1) : off_q;
		ovf_d          = ovf_q || ((ch_s1 != asl_pkg::CH_NUL) && (off_q == POS_MAX_B));
		first_start_d  = first_start_q;
		first_len_d    = first_len_q;
		first_dot_d    = first_dot_q;
		second_start_d = second_start_q;
		second_chars_d = second_chars_q;
		second_len_d   = second_len_q;
		label_start_d  = label_start_q;
		label_len_d    = label_len_q;
		op_kind_d      = op_kind_q;
		op_start_d     = op_start_q;
		op_len_d       = op_len_q;
		ops_start_d    = ops_start_q;
		assign_d       = assign_q;
		internal_d     = internal_q;

		case (phase_q)
			asl_pkg::PH_LEAD: begin
				if (!asl_pkg::is_blank(ch_s1)) begin
					if (asl_pkg::is_idstart(ch_s1)) begin
						first_start_d = off_q;
						first_len_d   = 5'd1;
						first_dot_d   = (ch_s1 == asl_pkg::CH_DOT);
						phase_d       = asl_pkg::PH_TOK1;
					end else begin
						ops_start_d = off_q;
						phase_d     = asl_pkg::PH_DONE;
					end
				end
			end
			asl_pkg::PH_TOK1: begin
				if (asl_pkg::is_idchar(ch_s1)) begin
					first_len_d = asl_pkg::sat_name(first_len_q);
				end else begin
					ph = asl_pkg::PH_AFTER1;
				end
			end
			asl_pkg::PH_COLON: begin
				phase_d = asl_pkg::PH_LBLWS;
				if (ch_s1 == asl_pkg::CH_COLON) begin
					internal_d = 1'b1;
					ph         = asl_pkg::PH_DONE;
				end else begin
					ph = asl_pkg::PH_LBLWS;
				end
			end
			asl_pkg::PH_OP: begin
				if (asl_pkg::is_idchar(ch_s1)) begin
					op_len_d = asl_pkg::sat_name(op_len_q);
				end else begin
					ph = asl_pkg::PH_OPWS;
				end
			end
			asl_pkg::PH_EQ1, asl_pkg::PH_EQ2: begin
				if ((ch_s1 == asl_pkg::CH_EQ) && (phase_q == asl_pkg::PH_EQ1)) begin
					phase_d = asl_pkg::PH_EQ2;
				end else if (ch_s1 == asl_pkg::CH_COLON) begin
					internal_d = 1'b1;
					phase_d    = asl_pkg::PH_OPWS;
				end else begin
					ph = asl_pkg::PH_OPWS;
				end
			end
			asl_pkg::PH_TOK2: begin
				if (asl_pkg::is_idchar(ch_s1)) begin
					if (second_len_q < 3'd4) begin
						second_chars_d[{second_len_q[1:0], 3'b000} +: 8] = ch_s1;
					end
					if (second_len_q < 3'd5) begin
						second_len_d = second_len_q + 3'd1;
					end
				end else if (kw_hit) begin
					label_start_d = first_start_q;
					label_len_d   = first_len_q;
					op_kind_d     = asl_pkg::OPK_IDENT;
					op_start_d    = second_start_q;
					op_len_d      = kw_len;
					assign_d      = 1'b1;
					ph            = asl_pkg::PH_OPWS;
				end else begin
					op_kind_d   = asl_pkg::OPK_IDENT;
					op_start_d  = first_start_q;
					op_len_d    = first_len_q;
					ops_start_d = second_start_q;
					phase_d     = asl_pkg::PH_DONE;
				end
			end
			asl_pkg::PH_AFTER1, asl_pkg::PH_LBLWS, asl_pkg::PH_OPWS: begin
			end
			default: begin
				phase_d = asl_pkg::PH_DONE;
			end
		endcase

		case (ph)
			asl_pkg::PH_AFTER1: begin
				phase_d = asl_pkg::PH_AFTER1;
				if (!asl_pkg::is_blank(ch_s1)) begin
					if (ch_s1 == asl_pkg::CH_COLON) begin
						label_start_d = first_start_q;
						label_len_d   = first_len_q;
						phase_d       = asl_pkg::PH_COLON;
					end else if (ch_s1 == asl_pkg::CH_EQ) begin
						label_start_d = first_start_q;
						label_len_d   = first_len_q;
						op_kind_d     = asl_pkg::OPK_EQUAL;
						assign_d      = 1'b1;
						phase_d       = asl_pkg::PH_EQ1;
					end else if (asl_pkg::is_idstart(ch_s1) && !first_dot_q) begin
						second_start_d = off_q;
						second_chars_d = {24'd0, ch_s1};
						second_len_d   = 3'd1;
						phase_d        = asl_pkg::PH_TOK2;
					end else begin
						op_kind_d   = asl_pkg::OPK_IDENT;
						op_start_d  = first_start_q;
						op_len_d    = first_len_q;
						ops_start_d = off_q;
						phase_d     = asl_pkg::PH_DONE;
					end
				end
			end
			asl_pkg::PH_LBLWS: begin
				phase_d = asl_pkg::PH_LBLWS;
				if (!asl_pkg::is_blank(ch_s1)) begin
					if (asl_pkg::is_idstart(ch_s1)) begin
						op_kind_d  = asl_pkg::OPK_IDENT;
						op_start_d = off_q;
						op_len_d   = 5'd1;
						phase_d    = asl_pkg::PH_OP;
					end else begin
						ops_start_d = off_q;
						phase_d     = asl_pkg::PH_DONE;
					end
				end
			end
			asl_pkg::PH_OPWS: begin
				phase_d = asl_pkg::PH_OPWS;
				if (!asl_pkg::is_blank(ch_s1)) begin
					ops_start_d = off_q;
					phase_d     = asl_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= asl_pkg::PH_LEAD;
			off_q          <= 8'd0;
			ovf_q          <= 1'b0;
			first_start_q  <= 8'd0;
			first_len_q    <= 5'd0;
			first_dot_q    <= 1'b0;
			second_start_q <= 8'd0;
			second_chars_q <= 32'd0;
			second_len_q   <= 3'd0;
			label_start_q  <= 8'd0;
			label_len_q    <= 5'd0;
			op_kind_q      <= asl_pkg::OPK_NONE;
			op_start_q     <= 8'd0;
			op_len_q       <= 5'd0;
			ops_start_q    <= 8'd0;
			assign_q       <= 1'b0;
			internal_q     <= 1'b0;
		end else if (proc) begin
			if (line_end) begin
				phase_q        <= asl_pkg::PH_LEAD;
				off_q          <= 8'd0;
				ovf_q          <= 1'b0;
				first_start_q  <= 8'd0;
				first_len_q    <= 5'd0;
				first_dot_q    <= 1'b0;
				second_start_q <= 8'd0;
				second_chars_q <= 32'd0;
				second_len_q   <= 3'd0;
				label_start_q  <= 8'd0;
				label_len_q    <= 5'd0;
				op_kind_q      <= asl_pkg::OPK_NONE;
				op_start_q     <= 8'd0;
				op_len_q       <= 5'd0;
				ops_start_q    <= 8'd0;
				assign_q       <= 1'b0;
				internal_q     <= 1'b0;
			end else begin
				phase_q        <= phase_d;
				off_q          <= off_d;
				ovf_q          <= ovf_d;
				first_start_q  <= first_start_d;
				first_len_q    <= first_len_d;
				first_dot_q    <= first_dot_d;
				second_start_q <= second_start_d;
				second_chars_q <= second_chars_d;
				second_len_q   <= second_len_d;
				label_start_q  <= label_start_d;
				label_len_q    <= label_len_d;
				op_kind_q      <= op_kind_d;
				op_start_q     <= op_start_d;
				op_len_q       <= op_len_d;
				ops_start_q    <= ops_start_d;
				assign_q       <= assign_d;
				internal_q     <= internal_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && line_end) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && line_end) begin
			out_label_start_q <= label_start_d;
			out_label_len_q   <= label_len_d;
			out_op_kind_q     <= op_kind_d;
			out_op_start_q    <= op_start_d;
			out_op_len_q      <= op_len_d;
			out_ops_start_q   <= ops_start_d;
			out_assign_q      <= assign_d;
			out_internal_q    <= internal_d;
			out_too_long_q    <= ovf_d;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.label_start    = out_label_start_q;
	assign results.label_len      = out_label_len_q;
	assign results.op_kind        = out_op_kind_q;
	assign results.op_start       = out_op_start_q;
	assign results.op_len         = out_op_len_q;
	assign results.operands_start = out_ops_start_q;
	assign results.is_assign      = out_assign_q;
	assign results.is_internal    = out_internal_q;
	assign results.too_long       = out_too_long_q;

endmodule

`default_nettype wire

>>> rtl/core/asl_checker.sv
// Port-level checker for the statement lexer and its bind to the top level.
`default_nettype none

`include "asm_statement_lexer_top_defines.svh"

module asl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] label_start,
	input wire logic [4:0] label_len,
	input wire logic [1:0] op_kind,
	input wire logic [7:0] op_start,
	input wire logic [4:0] op_len,
	input wire logic [7:0] operands_start,
	input wire logic       is_assign,
	input wire logic       is_internal,
	input wire logic       too_long
);

	logic [46:0] payload;

	assign payload = {label_start, label_len, op_kind, op_start, op_len, operands_start,
		is_assign, is_internal, too_long};

	// A result that is not taken stays offered and unchanged.
	`ASL_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(payload), "result changed while stalled")

	// Without a label its offset reads as zero.
	`ASL_ASSERT_NOW(a_no_label_zero, out_valid && (label_len == 5'd0), label_start == 8'd0, "label offset without label")

	// Only an identifier operator carries an offset and a length.
	`ASL_ASSERT_NOW(a_op_fields, out_valid && (op_kind != asl_pkg::OPK_IDENT), (op_start == 8'd0) && (op_len == 5'd0) && (op_kind != 2'd3), "operator fields without identifier")

	// Assignment and internal marks always come with a named symbol.
	`ASL_ASSERT_NOW(a_marks_need_label, out_valid && (is_assign || is_internal), label_len != 5'd0, "assignment or internal mark without symbol")

endmodule

bind asm_statement_lexer_top asl_checker u_asl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.label_start   (results.label_start),
	.label_len     (results.label_len),
	.op_kind       (results.op_kind),
	.op_start      (results.op_start),
	.op_len        (results.op_len),
	.operands_start(results.operands_start),
	.is_assign     (results.is_assign),
	.is_internal   (results.is_internal),
	.too_long      (results.too_long)
);

`default_nettype wire

>>> tb/tb_asm_statement_lexer_top.sv
// Self-checking testbench for the assembler statement lexer, with a built-in line predictor.
`timescale 1ns / 1ps

module tb_asm_statement_lexer_top;
	import asl_pkg::*;

	typedef struct packed {
		logic [7:0] label_start;
		logic [4:0] label_len;
		logic [1:0] op_kind;
		logic [7:0] op_start;
		logic [4:0] op_len;
		logic [7:0] operands_start;
		logic       is_assign;
		logic       is_internal;
		logic       too_long;
	} stmt_t;

	typedef struct {
		string      head;
		int         reps;
		logic [7:0] fill;
		string      tail;
		bit         typed_in;
		stmt_t      expv;
	} line_row_t;

	localparam int CYCLE_LIMIT = 400000;

	localparam stmt_t NO_STMT    = '0;
	localparam stmt_t FULL_LABEL = '{8'd0, 5'd31, OPK_NONE, 8'd0, 5'd0, 8'd41, 1'b0, 1'b0, 1'b0};
	localparam stmt_t OPS_AT_MAX = '{8'd0, 5'd0, OPK_NONE, 8'd0, 5'd0, 8'd255, 1'b0, 1'b0, 1'b0};
	localparam stmt_t OPS_OVER   = '{8'd0, 5'd0, OPK_NONE, 8'd0, 5'd0, 8'd255, 1'b0, 1'b0, 1'b1};
	localparam stmt_t OPS_AT_TWO = '{8'd0, 5'd0, OPK_NONE, 8'd0, 5'd0, 8'd2, 1'b0, 1'b0, 1'b0};

	line_row_t dir_rows[28] = '{
		'{"", 0, CH_SPACE, "", 1'b1, NO_STMT},
		'{"", 40, 8'h61, ":", 1'b1, FULL_LABEL},
		'{"", 255, CH_SPACE, "", 1'b1, OPS_AT_MAX},
		'{"", 260, CH_SPACE, "", 1'b1, OPS_OVER},
		'{";note", 0, CH_SPACE, "", 1'b1, NO_STMT},
		'{"  = 1", 0, CH_SPACE, "", 1'b1, OPS_AT_TWO},
		'{"lbl: nop a,b", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"lbl:: mov x", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"\tsym = 5", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"sym == 5", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"sym =: 5", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{" sym ==: 5", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"sym=", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"x EQU 1", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"y SET 2", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"z DEFL 3", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{".x EQU 1", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"a equ 1", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"a EQUX 1", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"lbl:nop", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"$%.9 x,y", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"1abc", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"a::: b", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"op", 36, 8'h62, " x", 1'b0, NO_STMT},
		'{"lbl: ", 40, 8'h63, "", 1'b0, NO_STMT},
		'{"nop ", 260, 8'h2C, "", 1'b0, NO_STMT},
		'{"q DEFL", 0, CH_SPACE, "", 1'b0, NO_STMT},
		'{"\377\200\001 x", 0, CH_SPACE, "", 1'b0, NO_STMT}
	};

	string keywords[8] = '{"EQU", "SET", "DEFL", "EQ", "DEFLX", "equ", "SETS", "DEF"};

	logic clk = 1'b0;
	logic arst_n;

	asl_char_if   chars_if();
	asl_result_if results_if();

	asm_statement_lexer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.results(results_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	phase_t      lx_phase;
	int          lx_pos;
	bit          lx_ovf;
	logic [7:0]  tok_start;
	logic [4:0]  tok_len;
	bit          tok_dot;
	logic [7:0]  sym_start;
	logic [31:0] sym_chars;
	logic [2:0]  sym_len;
	stmt_t       acc;

	stmt_t       pending_stmts[$];
	logic [7:0]  line_buf[$];
	int          send_idle;
	int          recv_idle;
	int          errors;
	int          cycles;
	int          rand_chars;
	int          rand_lines;
	int          stage;

	function automatic bit is_sp(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic bit is_lead(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_PCT);
	endfunction

	function automatic bit is_body(input logic [7:0] c);
		return is_lead(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [4:0] grow(input logic [4:0] n);
		return (int'(n) < NAME_LIM) ? n + 5'd1 : n;
	endfunction

	function automatic void clear_line();
		lx_phase  = PH_LEAD;
		lx_pos    = 0;
		lx_ovf    = 1'b0;
		tok_start = '0;
		tok_len   = '0;
		tok_dot   = 1'b0;
		sym_start = '0;
		sym_chars = '0;
		sym_len   = '0;
		acc       = '0;
	endfunction

	task automatic lex_char(input logic [7:0] c, output bit done, output stmt_t res);
		int         idx;
		int         eff;
		logic [7:0] off;
		bit         again;
		bit         kw;
		idx = lx_pos;
		off = (idx < POS_MAX) ? 8'(idx) : 8'(POS_MAX);
		if (c != CH_NUL && idx >= POS_MAX)
			lx_ovf = 1'b1;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (lx_phase)
				PH_LEAD: begin
					if (!is_sp(c)) begin
						if (is_lead(c)) begin
							tok_start = off;
							tok_len   = 5'd1;
							tok_dot   = (c == CH_DOT);
							lx_phase  = PH_TOK1;
						end else begin
							acc.operands_start = off;
							lx_phase = PH_DONE;
						end
					end
				end
				PH_TOK1: begin
					if (is_body(c)) begin
						tok_len = grow(tok_len);
					end else begin
						lx_phase = PH_AFTER1;
						again = 1'b1;
					end
				end
				PH_AFTER1: begin
					if (!is_sp(c)) begin
						if (c == CH_COLON) begin
							acc.label_start = tok_start;
							acc.label_len   = tok_len;
							lx_phase = PH_COLON;
						end else if (c == CH_EQ) begin
							acc.label_start = tok_start;
							acc.label_len   = tok_len;
							acc.op_kind     = OPK_EQUAL;
							acc.is_assign   = 1'b1;
							lx_phase = PH_EQ1;
						end else if (is_lead(c) && !tok_dot) begin
							sym_start = off;
							sym_chars = {24'd0, c};
							sym_len   = 3'd1;
							lx_phase  = PH_TOK2;
						end else begin
							acc.op_kind        = OPK_IDENT;
							acc.op_start       = tok_start;
							acc.op_len         = tok_len;
							acc.operands_start = off;
							lx_phase = PH_DONE;
						end
					end
				end
				PH_COLON: begin
					lx_phase = PH_LBLWS;
					if (c == CH_COLON)
						acc.is_internal = 1'b1;
					else
						again = 1'b1;
				end
				PH_LBLWS: begin
					if (!is_sp(c)) begin
						if (is_lead(c)) begin
							acc.op_kind  = OPK_IDENT;
							acc.op_start = off;
							acc.op_len   = 5'd1;
							lx_phase = PH_OP;
						end else begin
							acc.operands_start = off;
							lx_phase = PH_DONE;
						end
					end
				end
				PH_OP: begin
					if (is_body(c)) begin
						acc.op_len = grow(acc.op_len);
					end else begin
						lx_phase = PH_OPWS;
						again = 1'b1;
					end
				end
				PH_OPWS: begin
					if (!is_sp(c)) begin
						acc.operands_start = off;
						lx_phase = PH_DONE;
					end
				end
				PH_EQ1, PH_EQ2: begin
					if (c == CH_EQ && lx_phase == PH_EQ1) begin
						lx_phase = PH_EQ2;
					end else if (c == CH_COLON) begin
						acc.is_internal = 1'b1;
						lx_phase = PH_OPWS;
					end else begin
						lx_phase = PH_OPWS;
						again = 1'b1;
					end
				end
				PH_TOK2: begin
					if (is_body(c)) begin
						if (sym_len < 3'd4)
							sym_chars[8 * sym_len +: 8] = c;
						if (sym_len < 3'd5)
							sym_len = sym_len + 3'd1;
					end else begin
						eff = (int'(sym_len) > CMP_LIM) ? CMP_LIM : int'(sym_len);
						kw = (eff == 3 && (sym_chars[23:0] == KW_EQU ||
							sym_chars[23:0] == KW_SET)) ||
							(eff == 4 && sym_chars == KW_DEFL);
						if (kw) begin
							acc.label_start = tok_start;
							acc.label_len   = tok_len;
							acc.op_kind     = OPK_IDENT;
							acc.op_start    = sym_start;
							acc.op_len      = 5'((eff > NAME_LIM) ? NAME_LIM : eff);
							acc.is_assign   = 1'b1;
							lx_phase = PH_OPWS;
							again = 1'b1;
						end else begin
							acc.op_kind        = OPK_IDENT;
							acc.op_start       = tok_start;
							acc.op_len         = tok_len;
							acc.operands_start = sym_start;
							lx_phase = PH_DONE;
						end
					end
				end
				default: lx_phase = PH_DONE;
			endcase
		end
		if (idx < POS_MAX + 1)
			lx_pos = idx + 1;
		done = (c == CH_NUL);
		res = acc;
		res.too_long = lx_ovf;
		if (done)
			clear_line();
	endtask

	function automatic void add_blanks(input int hi);
		int n;
		n = $urandom_range(0, hi);
		repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endfunction

	function automatic void add_ident();
		int n;
		int r;
		n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
		r = $urandom_range(0, 9);
		if (r == 0)
			line_buf.push_back(CH_DOT);
		else if (r == 1)
			line_buf.push_back(CH_DOLLAR);
		else if (r == 2)
			line_buf.push_back(CH_PCT);
		else
			line_buf.push_back(8'($urandom_range(0, 1) ? 8'h41 : 8'h61) +
				8'($urandom_range(0, 25)));
		repeat (n - 1) begin
			if ($urandom_range(0, 4) == 0)
				line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
			else
				line_buf.push_back(8'($urandom_range(0, 1) ? 8'h41 : 8'h61) +
					8'($urandom_range(0, 25)));
		end
	endfunction

	function automatic void add_text();
		int n;
		n = $urandom_range(0, 8);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				line_buf.push_back(8'($urandom_range(1, 255)));
			else
				line_buf.push_back(8'($urandom_range(33, 126)));
		end
	endfunction

	function automatic void gen_line();
		string kw;
		int    n;
		line_buf.delete();
		add_blanks(3);
		case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(1, 12);
				repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
			end
			1, 2: begin
				add_ident();
				line_buf.push_back(CH_COLON);
				if ($urandom_range(0, 2) == 0)
					line_buf.push_back(CH_COLON);
				add_blanks(2);
				if ($urandom_range(0, 3) != 0)
					add_ident();
				add_blanks(2);
				add_text();
			end
			3, 4: begin
				add_ident();
				add_blanks(2);
				line_buf.push_back(CH_EQ);
				if ($urandom_range(0, 1))
					line_buf.push_back(CH_EQ);
				if ($urandom_range(0, 2) == 0)
					line_buf.push_back(CH_COLON);
				add_blanks(2);
				add_text();
			end
			5, 6: begin
				add_ident();
				line_buf.push_back(CH_SPACE);
				add_blanks(1);
				kw = keywords[$urandom_range(0, 7)];
				for (int i = 0; i < kw.len(); i++)
					line_buf.push_back(kw[i]);
				add_blanks(2);
				add_text();
			end
			7, 8: begin
				add_ident();
				add_blanks(2);
				add_text();
			end
			default: add_text();
		endcase
		if ($urandom_range(0, 29) == 0) begin
			n = $urandom_range(250, 270);
			while (line_buf.size() < n)
				line_buf.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	task automatic send_line(input bit typed_in, input stmt_t expv);
		bit    done;
		stmt_t res;
		line_buf.push_back(CH_NUL);
		foreach (line_buf[i]) begin
			while ($urandom_range(0, 99) < send_idle) begin
				chars_if.valid <= 1'b0;
				@(posedge clk);
			end
			chars_if.valid <= 1'b1;
			chars_if.ch    <= line_buf[i];
			@(posedge clk);
			while (!chars_if.ready)
				@(posedge clk);
			lex_char(line_buf[i], done, res);
			rand_chars++;
			if (done)
				pending_stmts.push_back(typed_in ? expv : res);
		end
	endtask

	task automatic drain();
		chars_if.valid <= 1'b0;
		while (pending_stmts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic next_stage();
		if (stage == 0 && rand_chars >= 420) begin
			drain();
			send_idle = 75;
			recv_idle = 35;
			stage = 1;
		end else if (stage == 1 && rand_chars >= 840) begin
			drain();
			send_idle = 0;
			recv_idle = 0;
			stage = 2;
		end
	endtask

	function automatic void check_field(input string name, input int unsigned e,
		input int unsigned a);
		if (e != a) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	task automatic check_stmt(input stmt_t got);
		stmt_t e;
		if (pending_stmts.size() == 0) begin
			$display("%0t: unexpected result transfer, expected none, got %h", $time, got);
			errors++;
		end else begin
			e = pending_stmts.pop_front();
			check_field("label_start", e.label_start, got.label_start);
			check_field("label_len", e.label_len, got.label_len);
			check_field("op_kind", e.op_kind, got.op_kind);
			check_field("op_start", e.op_start, got.op_start);
			check_field("op_len", e.op_len, got.op_len);
			check_field("operands_start", e.operands_start, got.operands_start);
			check_field("is_assign", e.is_assign, got.is_assign);
			check_field("is_internal", e.is_internal, got.is_internal);
			check_field("too_long", e.too_long, got.too_long);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready)
				check_stmt('{results_if.label_start, results_if.label_len,
					results_if.op_kind, results_if.op_start, results_if.op_len,
					results_if.operands_start, results_if.is_assign,
					results_if.is_internal, results_if.too_long});
			results_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch = CH_NUL;
		results_if.ready = 1'b0;
		send_idle = 35;
		recv_idle = 75;
		errors = 0;
		cycles = 0;
		stage = 0;
		rand_chars = 0;
		rand_lines = 0;
		clear_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			next_stage();
			line_buf.delete();
			for (int i = 0; i < dir_rows[r].head.len(); i++)
				line_buf.push_back(dir_rows[r].head[i]);
			repeat (dir_rows[r].reps) line_buf.push_back(dir_rows[r].fill);
			for (int i = 0; i < dir_rows[r].tail.len(); i++)
				line_buf.push_back(dir_rows[r].tail[i]);
			send_line(dir_rows[r].typed_in, dir_rows[r].expv);
		end

		while (rand_chars < 1250 || rand_lines < 8) begin
			next_stage();
			gen_line();
			send_line(1'b0, NO_STMT);
			rand_lines++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
